// ===== hw/rtl/btg_pkg.sv =====
package btg_pkg;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 31;

    localparam logic [CFG_INDEX_W-1:0] REG_PHASE_INCREMENT = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ON_LENGTH       = 1'd1;

    localparam logic [30:0] PHASE_INCREMENT_RESET = 31'd228170138;
    localparam logic [15:0] ON_LENGTH_RESET       = 16'd4000;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic signed [63:0] ONE_Q30 = 64'sd1073741824;

    typedef struct packed {
        logic [14:0] amplitude;
        logic        last_in_request;
    } req_t;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               tone_active;
        logic               last_out;
    } rsp_t;

    // Q30 sine of a full-turn phase, Taylor series to x^11 on the folded angle
    function automatic logic signed [63:0] sin_q30(input logic [31:0] ph);
        logic [1:0]         quad;
        logic [63:0]        x;
        logic [63:0]        r;
        logic [63:0]        r2;
        logic [63:0]        term;
        logic [63:0]        prod;
        logic signed [63:0] sum;
        quad = ph[31:30];
        x = {34'd0, ph[29:0]};
        if (quad[0])
        begin
            x = 64'h4000_0000 - x;
        end
        prod = x * HALF_PI_Q30;
        r = prod >> 30;
        prod = r * r;
        r2 = prod >> 30;
        term = r;
        sum = $signed(r);
        prod = term * r2;
        term = (prod >> 30) / 64'd6;
        sum = sum - $signed(term);
        prod = term * r2;
        term = (prod >> 30) / 64'd20;
        sum = sum + $signed(term);
        prod = term * r2;
        term = (prod >> 30) / 64'd42;
        sum = sum - $signed(term);
        prod = term * r2;
        term = (prod >> 30) / 64'd72;
        sum = sum + $signed(term);
        prod = term * r2;
        term = (prod >> 30) / 64'd110;
        sum = sum - $signed(term);
        if (sum < 0)
        begin
            sum = 64'sd0;
        end
        if (sum > ONE_Q30)
        begin
            sum = ONE_Q30;
        end
        return quad[1] ? -sum : sum;
    endfunction

    function automatic logic signed [15:0] sine_entry(input int k, input int abits);
        logic [63:0]        t;
        logic signed [63:0] s;
        logic signed [63:0] mag;
        logic signed [63:0] q;
        t = 64'(k) << (32 - abits);
        s = sin_q30(t[31:0]);
        mag = (s < 0) ? -s : s;
        q = (mag + 64'sd16384) >>> 15;
        if (q > 64'sd32767)
        begin
            q = 64'sd32767;
        end
        if (s < 0)
        begin
            q = -q;
        end
        return q[15:0];
    endfunction

endpackage

// ===== hw/rtl/busy_tone_generator.sv =====
// Busy-tone generator: one cadenced, ramped tone sample per request.
// Request channel: req_valid / req_stall with req_data (amplitude, last flag).
// Response channel: rsp_valid / rsp_stall with rsp_data (sample, tone flag, last).
// Config channel: cfg_valid / cfg_ready, cfg_index 0 = phase increment,
// 1 = on length; write only while no request is in progress.
// Each request steps through S_IDLE, S_MUL1, S_MUL2 and S_MUL3: the accept cycle
// reads the sine and head envelope ROMs, then one shared 16x16 multiplier is used
// three times (head ramp, tail ramp, amplitude). The response register loads at
// the end of the third multiply; a new request is taken only once the previous
// one has loaded its response.
// req_stall is high while a request is in progress. If rsp_stall holds the
// previous response, the block waits in its last step until the register frees;
// a held response does not change.
// Reset clears the cadence position and phase, restores the phase increment and
// 4000-sample on-length defaults and empties the response register.
module busy_tone_generator #(
    parameter int RAMP_LEN       = 40,
    parameter int SINE_ADDR_BITS = 10
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    output logic                               req_stall,
    input  btg_pkg::req_t                      req_data,
    output logic                               rsp_valid,
    input  logic                               rsp_stall,
    output btg_pkg::rsp_t                      rsp_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [btg_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [btg_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int SineSize = 1 << SINE_ADDR_BITS;
    localparam int EnvAw    = (RAMP_LEN > 1) ? $clog2(RAMP_LEN) : 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL1 = 2'd1;
    localparam logic [1:0] S_MUL2 = 2'd2;
    localparam logic [1:0] S_MUL3 = 2'd3;

    localparam logic [15:0] UNITY = 16'd32768;

    function automatic logic [15:0] env_entry(input int k);
        logic [63:0]        ph;
        logic [31:0]        ang;
        logic signed [63:0] c;
        logic signed [63:0] e;
        ph = (64'(k) << 32) / (2 * RAMP_LEN);
        ang = ph[31:0] + 32'h4000_0000;
        c = btg_pkg::sin_q30(ang);
        e = ((btg_pkg::ONE_Q30 - c) + 64'sd32768) >>> 16;
        if (e > 64'sd32768)
        begin
            e = 64'sd32768;
        end
        if (e < 0)
        begin
            e = 64'sd0;
        end
        return e[15:0];
    endfunction

    logic signed [15:0] sine_rom [SineSize];
    logic [15:0]        env_rom [RAMP_LEN];

    for (genvar k = 0; k < SineSize; k++)
    begin : g_sine
        localparam logic signed [15:0] Val = btg_pkg::sine_entry(k, SINE_ADDR_BITS);
        assign sine_rom[k] = Val;
    end

    for (genvar k = 0; k < RAMP_LEN; k++)
    begin : g_env
        localparam logic [15:0] Val = env_entry(k);
        assign env_rom[k] = Val;
    end

    logic [1:0]          state_reg, state_next;
    logic [16:0]         pos_reg, pos_next;
    logic [31:0]         acc_reg, acc_next;
    logic [30:0]         phase_inc_reg, phase_inc_next;
    logic [15:0]         on_len_reg, on_len_next;
    logic [14:0]         amp_reg, amp_next;
    logic                last_reg, last_next;
    logic                active_reg, active_next;
    logic                head_reg, head_next;
    logic                tail_hit_reg, tail_hit_next;
    logic [EnvAw-1:0]    tail_idx_reg, tail_idx_next;
    logic                sign_reg, sign_next;
    logic [15:0]         mag_reg, mag_next;
    logic                rsp_valid_reg, rsp_valid_next;
    btg_pkg::rsp_t       rsp_reg, rsp_next;
    logic signed [15:0]  sine_q_reg;
    logic [15:0]         env_q_reg;

    logic                    accept;
    logic [16:0]             on_ext;
    logic [16:0]             tail;
    logic [17:0]             pos_inc;
    logic [31:0]             acc_eff;
    logic                    cur_active;
    logic [SINE_ADDR_BITS-1:0] sine_addr;
    logic [EnvAw-1:0]        env_addr;
    logic [15:0]             sine_mag;
    logic [15:0]             mul_a;
    logic [15:0]             mul_b;
    logic [31:0]             mul_p;
    logic [31:0]             mul_rnd;
    logic [15:0]             mul_q;

    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    assign on_ext     = {1'b0, on_len_reg};
    assign tail       = on_ext - 17'd1 - pos_reg;
    assign pos_inc    = {1'b0, pos_reg} + 18'd1;
    assign acc_eff    = (pos_reg == 17'd0) ? 32'd0 : acc_reg;
    assign cur_active = pos_reg < on_ext;
    assign sine_addr  = acc_eff[31 -: SINE_ADDR_BITS];
    assign sine_mag   = sine_q_reg[15] ? 16'(-sine_q_reg) : sine_q_reg;

    // shared multiplier, Q15 with round half up on the magnitude
    assign mul_p   = mul_a * mul_b;
    assign mul_rnd = mul_p + 32'd16384;
    assign mul_q   = mul_rnd[30:15];

    always_comb
    begin
        mul_a = mag_reg;
        mul_b = UNITY;
        env_addr = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                env_addr = (cur_active && (pos_reg < 17'(RAMP_LEN))) ?
                           pos_reg[EnvAw-1:0] : '0;
            end
            S_MUL1:
            begin
                mul_a = active_reg ? sine_mag : 16'd0;
                mul_b = head_reg ? env_q_reg : UNITY;
                env_addr = tail_idx_reg;
            end
            S_MUL2:
            begin
                mul_b = tail_hit_reg ? env_q_reg : UNITY;
            end
            S_MUL3:
            begin
                mul_b = {1'b0, amp_reg};
            end
            default:
            begin
                mul_b = UNITY;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        acc_next       = acc_reg;
        phase_inc_next = phase_inc_reg;
        on_len_next    = on_len_reg;
        amp_next       = amp_reg;
        last_next      = last_reg;
        active_next    = active_reg;
        head_next      = head_reg;
        tail_hit_next  = tail_hit_reg;
        tail_idx_next  = tail_idx_reg;
        sign_next      = sign_reg;
        mag_next       = mag_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;

        if (cfg_valid)
        begin
            unique case (cfg_index)
                btg_pkg::REG_PHASE_INCREMENT: phase_inc_next = cfg_data;
                btg_pkg::REG_ON_LENGTH:       on_len_next = cfg_data[15:0];
                default:                      on_len_next = on_len_reg;
            endcase
        end

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    amp_next      = req_data.amplitude;
                    last_next     = req_data.last_in_request;
                    active_next   = cur_active;
                    head_next     = cur_active && (pos_reg < 17'(RAMP_LEN));
                    tail_hit_next = cur_active && (tail < 17'(RAMP_LEN));
                    tail_idx_next = (cur_active && (tail < 17'(RAMP_LEN))) ?
                                    tail[EnvAw-1:0] : '0;
                    acc_next      = cur_active ? acc_eff + {1'b0, phase_inc_reg} : acc_eff;
                    pos_next      = (pos_inc >= {1'b0, on_len_reg, 1'b0}) ?
                                    17'd0 : pos_inc[16:0];
                    state_next    = S_MUL1;
                end
            end
            S_MUL1:
            begin
                mag_next   = mul_q;
                sign_next  = sine_q_reg[15];
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                mag_next   = mul_q;
                state_next = S_MUL3;
            end
            S_MUL3:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next.sample      = sign_reg ? -$signed(mul_q) : $signed(mul_q);
                    rsp_next.tone_active = active_reg;
                    rsp_next.last_out    = last_reg;
                    rsp_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            acc_reg       <= '0;
            phase_inc_reg <= btg_pkg::PHASE_INCREMENT_RESET;
            on_len_reg    <= btg_pkg::ON_LENGTH_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            acc_reg       <= acc_next;
            phase_inc_reg <= phase_inc_next;
            on_len_reg    <= on_len_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        amp_reg      <= amp_next;
        last_reg     <= last_next;
        active_reg   <= active_next;
        head_reg     <= head_next;
        tail_hit_reg <= tail_hit_next;
        tail_idx_reg <= tail_idx_next;
        sign_reg     <= sign_next;
        mag_reg      <= mag_next;
        rsp_reg      <= rsp_next;
    end

    // ROM reads, registered
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sine_q_reg <= sine_rom[sine_addr];
        end
        env_q_reg <= env_rom[env_addr];
    end

endmodule

// ===== dv/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RAMP_LEN       = 40;
    localparam int SINE_ADDR_BITS = 10;
    localparam int SINE_SIZE      = 1 << SINE_ADDR_BITS;
    localparam int BATCH_TARGET   = 1250;

    logic                            clk;
    logic                            rst_n     = 1'b0;
    logic                            req_valid = 1'b0;
    logic                            req_stall;
    btg_pkg::req_t                   req_data  = '0;
    logic                            rsp_valid;
    logic                            rsp_stall = 1'b0;
    btg_pkg::rsp_t                   rsp_data;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [btg_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [btg_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

    busy_tone_generator #(
        .RAMP_LEN       (RAMP_LEN),
        .SINE_ADDR_BITS (SINE_ADDR_BITS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // cadence model state and its copy of the registers
    logic signed [15:0] sine_lut [SINE_SIZE];
    logic [15:0]        ramp_lut [RAMP_LEN];
    logic [30:0]        tone_inc   = btg_pkg::PHASE_INCREMENT_RESET;
    logic [15:0]        tone_on    = btg_pkg::ON_LENGTH_RESET;
    logic [16:0]        tone_pos   = '0;
    logic [31:0]        tone_phase = '0;

    btg_pkg::req_t request_feed [$];
    btg_pkg::rsp_t tone_expected [$];
    btg_pkg::rsp_t tone_want;

    bit steady = 1'b0;
    int items_issued = 0;
    int results_seen = 0;
    int mismatches = 0;
    int tone_seen = 0;
    int silence_seen = 0;
    int settings_seen = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Q30 sine over a full turn, odd Taylor terms to x^11 on the folded angle
    function automatic longint sine_q30(input logic [31:0] ph);
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] r2;
        logic [63:0] term;
        logic [63:0] div;
        longint      acc;
        x = {34'd0, ph[29:0]};
        if (ph[30])
        begin
            x = 64'h4000_0000 - x;
        end
        r = (x * btg_pkg::HALF_PI_Q30) >> 30;
        r2 = (r * r) >> 30;
        term = r;
        acc = longint'(r);
        for (int k = 1; k <= 5; k++)
        begin
            div = 64'((2 * k) * (2 * k + 1));
            term = ((term * r2) >> 30) / div;
            if (k % 2 == 1)
            begin
                acc = acc - longint'(term);
            end
            else
            begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0)
        begin
            acc = 0;
        end
        if (acc > btg_pkg::ONE_Q30)
        begin
            acc = btg_pkg::ONE_Q30;
        end
        return ph[31] ? -acc : acc;
    endfunction

    task automatic fill_tables();
        longint      s;
        longint      mag;
        longint      q;
        logic [63:0] wide;
        for (int k = 0; k < SINE_SIZE; k++)
        begin
            wide = 64'(k) << (32 - SINE_ADDR_BITS);
            s = sine_q30(wide[31:0]);
            mag = (s < 0) ? -s : s;
            q = (mag + 16384) >>> 15;
            if (q > 32767)
            begin
                q = 32767;
            end
            sine_lut[k] = (s < 0) ? 16'(-q) : 16'(q);
        end
        for (int k = 0; k < RAMP_LEN; k++)
        begin
            wide = (64'(k) << 32) / 64'(2 * RAMP_LEN);
            s = sine_q30(wide[31:0] + 32'h4000_0000);
            q = ((btg_pkg::ONE_Q30 - s) + 32768) >>> 16;
            if (q > 32768)
            begin
                q = 32768;
            end
            if (q < 0)
            begin
                q = 0;
            end
            ramp_lut[k] = 16'(q);
        end
    endtask

    // signed Q15 times unsigned Q15 gain, rounded half away from zero
    function automatic int gain_q15(input int a, input int unsigned g);
        logic [63:0] m;
        logic [63:0] p;
        m = (a < 0) ? 64'(-longint'(a)) : 64'(a);
        p = (m * 64'(g) + 64'd16384) >> 15;
        return (a < 0) ? -int'(p) : int'(p);
    endfunction

    function automatic btg_pkg::rsp_t next_tone(input btg_pkg::req_t r);
        int            v;
        logic [16:0]   tail;
        logic [17:0]   period;
        logic [17:0]   nxt;
        btg_pkg::rsp_t o;
        v = 0;
        o.tone_active = 1'b0;
        if (tone_pos == 0)
        begin
            tone_phase = '0;
        end
        if (tone_pos < tone_on)
        begin
            tail = 17'(tone_on) - 17'd1 - tone_pos;
            o.tone_active = 1'b1;
            v = sine_lut[tone_phase[31 -: SINE_ADDR_BITS]];
            if (tone_pos < RAMP_LEN)
            begin
                v = gain_q15(v, ramp_lut[tone_pos]);
            end
            if (tail < RAMP_LEN)
            begin
                v = gain_q15(v, ramp_lut[tail]);
            end
            v = gain_q15(v, r.amplitude);
            tone_phase = tone_phase + {1'b0, tone_inc};
        end
        if (v > 32767)
        begin
            v = 32767;
        end
        if (v < -32768)
        begin
            v = -32768;
        end
        period = {1'b0, tone_on, 1'b0};
        nxt = {1'b0, tone_pos} + 18'd1;
        if (nxt >= period)
        begin
            nxt = '0;
        end
        tone_pos = nxt[16:0];
        o.sample = v[15:0];
        o.last_out = r.last_in_request;
        return o;
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req_data <= '0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                tone_expected.push_back(next_tone(req_data));
            end
            if (!req_valid || !req_stall)
            begin
                if (request_feed.size() != 0 && (steady || $urandom_range(99) >= 25))
                begin
                    req_valid <= 1'b1;
                    req_data <= request_feed.pop_front();
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // response monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (tone_expected.size() == 0)
                begin
                    $display("%0t: unexpected response, expected none got %h", $time,
                             rsp_data);
                    mismatches++;
                end
                else
                begin
                    tone_want = tone_expected.pop_front();
                    results_seen++;
                    if (rsp_data.sample !== tone_want.sample)
                    begin
                        $display("%0t: sample expected %0d got %0d", $time,
                                 tone_want.sample, rsp_data.sample);
                        mismatches++;
                    end
                    if (rsp_data.tone_active !== tone_want.tone_active)
                    begin
                        $display("%0t: tone_active expected %b got %b", $time,
                                 tone_want.tone_active, rsp_data.tone_active);
                        mismatches++;
                    end
                    if (rsp_data.last_out !== tone_want.last_out)
                    begin
                        $display("%0t: last_out expected %b got %b", $time,
                                 tone_want.last_out, rsp_data.last_out);
                        mismatches++;
                    end
                    if (tone_want.tone_active)
                    begin
                        tone_seen++;
                    end
                    else
                    begin
                        silence_seen++;
                    end
                end
            end
            rsp_stall <= !steady && ($urandom_range(99) < 25);
        end
    end

    task automatic send_request(input logic [14:0] amp, input logic last);
        btg_pkg::req_t r;
        r.amplitude = amp;
        r.last_in_request = last;
        request_feed.push_back(r);
        items_issued++;
    endtask

    task automatic drain();
        while (results_seen != items_issued)
        begin
            @(posedge clk);
        end
    endtask

    // only called with the block idle
    task automatic program_cadence(input bit set_inc, input logic [30:0] inc,
                                   input bit set_on, input logic [15:0] on);
        cfg_valid <= 1'b1;
        if (set_inc)
        begin
            cfg_index <= btg_pkg::REG_PHASE_INCREMENT;
            cfg_data <= inc;
            do @(posedge clk); while (!cfg_ready);
            tone_inc = inc;
        end
        if (set_on)
        begin
            cfg_index <= btg_pkg::REG_ON_LENGTH;
            cfg_data <= {15'd0, on};
            do @(posedge clk); while (!cfg_ready);
            tone_on = on;
        end
        cfg_valid <= 1'b0;
        settings_seen++;
    endtask

    function automatic logic [14:0] random_amplitude();
        int pick;
        pick = $urandom_range(19);
        if (pick < 2)
        begin
            return 15'h7FFF;
        end
        if (pick == 2)
        begin
            return 15'd0;
        end
        return 15'($urandom());
    endfunction

    initial
    begin
        int          batch;
        int          pick;
        int          mask;
        int          count;
        logic [30:0] inc;
        logic [15:0] on;
        fill_tables();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset cadence, amplitude extremes and bit patterns
        send_request(15'h7FFF, 1'b0);
        send_request(15'h7FFF, 1'b1);
        send_request(15'd0, 1'b0);
        send_request(15'd1, 1'b1);
        send_request(15'h4000, 1'b0);
        send_request(15'h5555, 1'b1);
        send_request(15'h2AAA, 1'b0);
        drain();
        program_cadence(1'b1, 31'h7FFF_FFFF, 1'b1, 16'hFFFF);
        repeat (3) send_request(15'h7FFF, 1'b1);
        drain();
        // position now beyond the shorter period: silent sample, then wrap
        program_cadence(1'b1, 31'd1, 1'b1, 16'd2);
        repeat (5) send_request(15'h7FFF, 1'b0);
        drain();
        program_cadence(1'b0, '0, 1'b1, 16'd0);
        repeat (3) send_request(15'h7FFF, 1'b1);
        drain();
        program_cadence(1'b1, btg_pkg::PHASE_INCREMENT_RESET, 1'b1, 16'd1);
        repeat (3) send_request(15'h7FFF, 1'b0);
        drain();

        batch = 0;
        while (items_issued < BATCH_TARGET)
        begin
            case ($urandom_range(7))
                0: inc = 31'd1;
                1: inc = 31'h7FFF_FFFF;
                2: inc = 31'd214748365;
                3: inc = 31'd332859965;
                4: inc = 31'd0;
                default: inc = 31'($urandom());
            endcase
            pick = $urandom_range(9);
            if (pick < 6)
            begin
                on = 16'($urandom_range(120, 1));
            end
            else if (pick < 8)
            begin
                on = 16'($urandom_range(400, 121));
            end
            else if (pick == 8)
            begin
                on = 16'($urandom_range(3));
            end
            else
            begin
                on = $urandom_range(1) ? 16'd3200 : 16'hFFFF;
            end
            mask = $urandom_range(3, 1);
            program_cadence(mask[0], inc, mask[1], on);
            steady = (batch == 3);
            count = $urandom_range(170, 80);
            if (count > BATCH_TARGET - items_issued)
            begin
                count = BATCH_TARGET - items_issued;
            end
            repeat (count)
            begin
                send_request(random_amplitude(), 1'($urandom_range(1)));
            end
            drain();
            steady = 1'b0;
            batch++;
        end

        repeat (20) @(posedge clk);
        $display("Checked %0d samples (%0d tone, %0d silent) over %0d cadence settings",
                 results_seen, tone_seen, silence_seen, settings_seen);
        if (mismatches == 0 && tone_expected.size() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
